[rtl/core/mhf_pkg.sv]
// Shared widths, latencies, register indexes and types of the metaball heat field shader.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mhf_pkg;

  // Field widths.
  localparam int COORD_W    = 10;
  localparam int RAD_W      = 9;
  localparam int LEVEL_W    = 8;
  localparam int MAX_BLOBS  = 2;

  // Distance has 8 fraction bits, so the radicand carries 16.
  localparam int D_FRAC     = 8;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int RR_W       = 2 * RAD_W;
  localparam int RT_IN_W    = ((SQ_W + 2 * D_FRAC + 1) / 2) * 2;
  localparam int RT_OUT_W   = RT_IN_W / 2;
  localparam int RQ8_W      = RAD_W + D_FRAC;
  localparam int NUM_W      = RQ8_W + D_FRAC;
  localparam int HEAT_W     = 2 * D_FRAC + 1;
  localparam int SUM_W      = HEAT_W + 1;

  localparam int SCALE_W    = 8;
  localparam logic [SCALE_W-1:0] LEVEL_SCALE = 8'd170;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd255;
  localparam int PROD_W     = SUM_W + SCALE_W;
  localparam int HEAT_FRAC  = 2 * D_FRAC;

  // Three front stages, one per root bit, one preparation stage, one per quotient bit.
  localparam int LANE_LAT   = 3 + RT_OUT_W + 1 + HEAT_W;
  // Sum stage and level stage follow the lanes.
  localparam int PIPE_LAT   = LANE_LAT + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_B0_CX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B0_CY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B0_R  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_CX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_CY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_R  = 3'd5;

  // Register reset values.
  localparam logic [COORD_W-1:0] RST_B0_CX = 10'd300;
  localparam logic [COORD_W-1:0] RST_B0_CY = 10'd200;
  localparam logic [RAD_W-1:0]   RST_B0_R  = 9'd100;
  localparam logic [COORD_W-1:0] RST_B1_CX = 10'd400;
  localparam logic [COORD_W-1:0] RST_B1_CY = 10'd230;
  localparam logic [RAD_W-1:0]   RST_B1_R  = 9'd75;

  // Parameter defaults.
  localparam int DEF_NUM_BLOBS = 2;
  localparam int DEF_WIDTH     = 1024;
  localparam int DEF_HEIGHT    = 1024;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [RAD_W-1:0]   r;
  } blob_cfg_t;

endpackage

[rtl/core/mhf_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on mhf_pkg for its default width.
module mhf_sqrt #(
  parameter int IN_W = mhf_pkg::RT_IN_W
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [IN_W-1:0]  v_q    [OUT_W-1];
  logic [REM_W-1:0] rem_q  [OUT_W-1];
  logic [OUT_W-1:0] root_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [IN_W-1:0]  src;
    logic [REM_W-1:0] rem_src;
    logic [OUT_W-1:0] root_src;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] tsub;
    logic             ge;

    if (k == 0) begin : g_first
      assign src      = rad_i;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign src      = v_q[k-1];
      assign rem_src  = rem_q[k-1];
      assign root_src = root_q[k-1];
    end

    // Bring down the next pair of radicand bits and try root*4+1.
    assign trial = {rem_src, src[IN_W-1 -: 2]};
    assign tsub  = {2'b00, root_src, 2'b01};
    assign ge    = (trial >= tsub);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_src[OUT_W-2:0], ge};
      end
    end

    if (k < OUT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[k]   <= src << 2;
          rem_q[k] <= ge ? REM_W'(trial - tsub) : REM_W'(trial);
        end
      end
    end
  end

  assign root_o = root_q[OUT_W-1];

endmodule

[rtl/core/mhf_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on mhf_pkg for its default widths; the quotient must fit in Q_W bits.
module mhf_div #(
  parameter int NUM_W = mhf_pkg::NUM_W,
  parameter int D_W   = mhf_pkg::RAD_W,
  parameter int Q_W   = mhf_pkg::HEAT_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [D_W-1:0]   den_i,
  output logic [Q_W-1:0]   quo_o
);

  logic [Q_W-1:0] n_q   [Q_W-1];
  logic [D_W-1:0] rem_q [Q_W-1];
  logic [Q_W-1:0] quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [Q_W-1:0] bsrc;
    logic [D_W-1:0] rem_src;
    logic [Q_W-1:0] quo_src;
    logic [D_W:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      // The upper numerator bits are known to stay below the divisor.
      assign bsrc    = num_i[Q_W-1:0];
      assign rem_src = D_W'(num_i[NUM_W-1:Q_W]);
      assign quo_src = '0;
    end else begin : g_next
      assign bsrc    = n_q[k-1];
      assign rem_src = rem_q[k-1];
      assign quo_src = quo_q[k-1];
    end

    assign trial = {rem_src, bsrc[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_src[Q_W-2:0], ge};
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[k]   <= bsrc << 1;
          rem_q[k] <= ge ? D_W'(trial - {1'b0, den_i}) : D_W'(trial);
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

[rtl/core/mhf_blob.sv]
// One blob lane: distance squared, square root, falloff division into a heat value.
// Depends on mhf_pkg, mhf_sqrt and mhf_div.
module mhf_blob (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [mhf_pkg::COORD_W-1:0]  px_i,
  input  logic [mhf_pkg::COORD_W-1:0]  py_i,
  input  mhf_pkg::blob_cfg_t           cfg_i,
  output logic [mhf_pkg::HEAT_W-1:0]   heat_o
);

  localparam int CW    = mhf_pkg::COORD_W;
  localparam int CH_W  = mhf_pkg::RT_OUT_W + 1 + mhf_pkg::HEAT_W;

  logic [CW-1:0]                dx_q, dy_q;
  logic                         nz_q, nz2_q;
  logic [2*CW-1:0]              dx2_q, dy2_q;
  logic [mhf_pkg::RR_W-1:0]     rr_q;
  logic [mhf_pkg::SQ_W-1:0]     sq_q;
  logic                         in_q;
  logic [CH_W-1:0]              in_sr_q;
  logic [mhf_pkg::RT_OUT_W-1:0] root;
  logic [mhf_pkg::RQ8_W-1:0]    rq8;
  logic [mhf_pkg::RQ8_W-1:0]    dcl;
  logic [mhf_pkg::NUM_W-1:0]    num_d, num_q;
  logic [mhf_pkg::HEAT_W-1:0]   quo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= (px_i >= cfg_i.cx) ? px_i - cfg_i.cx : cfg_i.cx - px_i;
      dy_q  <= (py_i >= cfg_i.cy) ? py_i - cfg_i.cy : cfg_i.cy - py_i;
      nz_q  <= (cfg_i.r != '0);
      dx2_q <= dx_q * dx_q;
      dy2_q <= dy_q * dy_q;
      rr_q  <= cfg_i.r * cfg_i.r;
      nz2_q <= nz_q;
      sq_q  <= mhf_pkg::SQ_W'(dx2_q) + mhf_pkg::SQ_W'(dy2_q);
      in_q  <= nz2_q && ((mhf_pkg::SQ_W'(dx2_q) + mhf_pkg::SQ_W'(dy2_q))
                         <= mhf_pkg::SQ_W'(rr_q));
      in_sr_q <= {in_sr_q[CH_W-2:0], in_q};
    end
  end

  mhf_sqrt #(
    .IN_W (mhf_pkg::RT_IN_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (mhf_pkg::RT_IN_W'({sq_q, {(2 * mhf_pkg::D_FRAC){1'b0}}})),
    .root_o (root)
  );

  // Falloff numerator (r - d) in 16 fraction bits; zero outside the blob.
  always_comb begin
    rq8 = {cfg_i.r, {mhf_pkg::D_FRAC{1'b0}}};
    dcl = (root > mhf_pkg::RT_OUT_W'(rq8)) ? rq8 : mhf_pkg::RQ8_W'(root);
    num_d = in_sr_q[mhf_pkg::RT_OUT_W-1]
          ? {rq8 - dcl, {mhf_pkg::D_FRAC{1'b0}}} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
    end
  end

  mhf_div #(
    .NUM_W (mhf_pkg::NUM_W),
    .D_W   (mhf_pkg::RAD_W),
    .Q_W   (mhf_pkg::HEAT_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (cfg_i.r),
    .quo_o (quo)
  );

  // A zero radius would make the divider saturate, so the inside flag masks it.
  assign heat_o = in_sr_q[CH_W-1] ? quo : '0;

endmodule

[rtl/core/metaball_heat_field_shader_core.sv]
// Top level of the metaball heat field shader: configuration registers, blob lanes,
// valid pipeline and output level stage. Depends on mhf_pkg and mhf_blob.
//
// Usage. Each transfer on the input channel (in_valid_i high, in_stall_o low) carries
// one pixel coordinate; each transfer on the output channel (out_valid_o high,
// out_stall_i low) carries the 8-bit level for red and green of one pixel, in order.
// Every pixel yields exactly one level. The blob centres and radii sit in six
// registers written through the configuration channel, which is always ready; they
// must only be changed while no pixel is in flight, since the lanes read them live.
//
// From the input transfer to the earliest output transfer, three stages form the squared
// distance, nineteen iterate the square root one bit each, one prepares the falloff,
// seventeen divide by the radius one quotient bit each, and two sum, scale and saturate.
// One pixel is taken every cycle unless the pipeline is frozen by a stalled receiver.
//
// Reset clears the valid bits of every stage and loads the default blob geometry.
// When the receiver stalls while a result is waiting, the whole pipeline freezes
// and in_stall_o rises in the same cycle; nothing is dropped or repeated.
module metaball_heat_field_shader_core #(
  parameter int NUM_BLOBS = mhf_pkg::DEF_NUM_BLOBS,
  parameter int WIDTH     = mhf_pkg::DEF_WIDTH,
  parameter int HEIGHT    = mhf_pkg::DEF_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mhf_pkg::COORD_W-1:0]    pixel_x_i,
  input  logic [mhf_pkg::COORD_W-1:0]    pixel_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mhf_pkg::LEVEL_W-1:0]    level_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mhf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mhf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LAT = mhf_pkg::PIPE_LAT;
  localparam int CW  = mhf_pkg::COORD_W;

  logic [CW-1:0]               cx_q [mhf_pkg::MAX_BLOBS];
  logic [CW-1:0]               cy_q [mhf_pkg::MAX_BLOBS];
  logic [mhf_pkg::RAD_W-1:0]   r_q  [mhf_pkg::MAX_BLOBS];
  mhf_pkg::blob_cfg_t          blob_cfg [mhf_pkg::MAX_BLOBS];

  logic                        en;
  logic                        off;
  logic [LAT-1:0]              vld_q;
  logic [LAT-1:0]              off_sr_q;
  logic [mhf_pkg::HEAT_W-1:0]  heat [NUM_BLOBS];
  logic [mhf_pkg::SUM_W-1:0]   sum_d, sum_q;
  logic [mhf_pkg::PROD_W-1:0]  prod;
  logic [mhf_pkg::PROD_W-mhf_pkg::HEAT_FRAC-1:0] lvl_wide;
  logic [mhf_pkg::LEVEL_W-1:0] level_d, level_q;

  // The configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q[0] <= mhf_pkg::RST_B0_CX;
      cy_q[0] <= mhf_pkg::RST_B0_CY;
      r_q[0]  <= mhf_pkg::RST_B0_R;
      cx_q[1] <= mhf_pkg::RST_B1_CX;
      cy_q[1] <= mhf_pkg::RST_B1_CY;
      r_q[1]  <= mhf_pkg::RST_B1_R;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mhf_pkg::CFG_B0_CX: cx_q[0] <= cfg_data_i[CW-1:0];
        mhf_pkg::CFG_B0_CY: cy_q[0] <= cfg_data_i[CW-1:0];
        mhf_pkg::CFG_B0_R:  r_q[0]  <= cfg_data_i[mhf_pkg::RAD_W-1:0];
        mhf_pkg::CFG_B1_CX: cx_q[1] <= cfg_data_i[CW-1:0];
        mhf_pkg::CFG_B1_CY: cy_q[1] <= cfg_data_i[CW-1:0];
        mhf_pkg::CFG_B1_R:  r_q[1]  <= cfg_data_i[mhf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < mhf_pkg::MAX_BLOBS; b++) begin
      blob_cfg[b].cx = cx_q[b];
      blob_cfg[b].cy = cy_q[b];
      blob_cfg[b].r  = r_q[b];
    end
  end

  // The pipeline only halts when a finished level is waiting on a stalled receiver.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign off = ({1'b0, pixel_x_i} >= (CW + 1)'(WIDTH))
            || ({1'b0, pixel_y_i} >= (CW + 1)'(HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      off_sr_q <= {off_sr_q[LAT-2:0], off};
    end
  end

  for (genvar b = 0; b < NUM_BLOBS; b++) begin : g_lane
    mhf_blob u_blob (
      .clk_i  (clk_i),
      .en_i   (en),
      .px_i   (pixel_x_i),
      .py_i   (pixel_y_i),
      .cfg_i  (blob_cfg[b]),
      .heat_o (heat[b])
    );
  end

  always_comb begin
    sum_d = '0;
    for (int b = 0; b < NUM_BLOBS; b++) begin
      sum_d = sum_d + mhf_pkg::SUM_W'(heat[b]);
    end
  end

  // Scale by 170 and drop the 16 fraction bits; levels above full scale clamp, and off-canvas pixels give zero.
  always_comb begin
    prod     = sum_q * mhf_pkg::LEVEL_SCALE;
    lvl_wide = prod[mhf_pkg::PROD_W-1:mhf_pkg::HEAT_FRAC];
    if (off_sr_q[LAT-2]) begin
      level_d = '0;
    end else if (lvl_wide > (mhf_pkg::PROD_W - mhf_pkg::HEAT_FRAC)'(mhf_pkg::LEVEL_MAX)) begin
      level_d = mhf_pkg::LEVEL_MAX;
    end else begin
      level_d = lvl_wide[mhf_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q   <= sum_d;
      level_q <= level_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign level_o     = level_q;

  // A waiting result that the receiver refuses must hold back the input side.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while a stalled result waits");

  // A frozen pipeline keeps every valid bit where it was.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // A pixel off the canvas always reads as black.
  a_off_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && off_sr_q[LAT-1] |-> level_o == '0)
    else $error("off-canvas pixel produced a nonzero level");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for metaball_heat_field_shader_core: pixel stream in, level stream out.
// Depends on mhf_pkg for widths, register indexes and reset geometry, and on the core itself.
module tb_top;

  // Clock period is 10 units. This limit is many times the slowest legal run, even with the
  // longest gaps and stalls on every transfer.
  localparam int RUN_LIMIT       = 2000000;
  localparam int LONG_HOLD       = 200;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int COORD_MAX       = (1 << mhf_pkg::COORD_W) - 1;

  // Indexes that decode to no register. A write to them must leave the geometry untouched.
  localparam logic [mhf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [mhf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  // One line of the directed table. For a pixel row, a and b are the column and the row.
  // For a register row, a holds the index and b the data. When known is set, level is the
  // expected level, read off directly. Otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_e                   kind;
    logic [9:0]                  a;
    logic [9:0]                  b;
    logic                        known;
    logic [mhf_pkg::LEVEL_W-1:0] level;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [mhf_pkg::COORD_W-1:0]    pixel_x_i;
  logic [mhf_pkg::COORD_W-1:0]    pixel_y_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [mhf_pkg::LEVEL_W-1:0]    level_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [mhf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [mhf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // This is the testbench's own copy of the blob geometry. It changes only when a write
  // transfer completes.
  mhf_pkg::blob_cfg_t          blob_model [mhf_pkg::MAX_BLOBS];
  // Levels still owed by the core, oldest first. An entry is pushed on each input transfer.
  logic [mhf_pkg::LEVEL_W-1:0] level_expected_q [$];
  stim_row_t                   directed_rows [$];
  int                          mismatch_count;
  bit                          sender_calm;
  bit                          receiver_calm;
  int                          long_hold_requested;

  metaball_heat_field_shader_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // This is the integer square root, one result bit per step. It gives floor(sqrt(v)).
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned rem, res, bitv;
    rem  = v;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // This is the linear falloff of one blob, with 16 fraction bits. The inside test is exact,
  // on squared distances, and a pixel at exactly the radius contributes nothing. The distance
  // itself keeps 8 fraction bits.
  function automatic logic [mhf_pkg::HEAT_W-1:0] blob_falloff(
      input logic [mhf_pkg::COORD_W-1:0] px,
      input logic [mhf_pkg::COORD_W-1:0] py,
      input mhf_pkg::blob_cfg_t blob);
    longint unsigned dx, dy, sq, rad, dq8, rq8;
    rad = blob.r;
    if (rad == 0) return '0;
    dx = (px >= blob.cx) ? px - blob.cx : blob.cx - px;
    dy = (py >= blob.cy) ? py - blob.cy : blob.cy - py;
    sq = dx * dx + dy * dy;
    if (sq > rad * rad) return '0;
    dq8 = int_root(sq << 16);
    rq8 = rad << mhf_pkg::D_FRAC;
    if (dq8 > rq8) dq8 = rq8;
    return mhf_pkg::HEAT_W'(((rq8 - dq8) << mhf_pkg::D_FRAC) / rad);
  endfunction

  // This gives the level for one pixel. The sum of the falloffs is scaled by 170/65536 and
  // truncated, then clamped to 8 bits.
  function automatic logic [mhf_pkg::LEVEL_W-1:0] shade_level(
      input logic [mhf_pkg::COORD_W-1:0] px,
      input logic [mhf_pkg::COORD_W-1:0] py);
    longint unsigned heat_sum, lvl;
    if (px >= mhf_pkg::DEF_WIDTH || py >= mhf_pkg::DEF_HEIGHT) return '0;
    heat_sum = 0;
    for (int b = 0; b < mhf_pkg::DEF_NUM_BLOBS; b++) begin
      heat_sum += blob_falloff(px, py, blob_model[b]);
    end
    lvl = (heat_sum * mhf_pkg::LEVEL_SCALE) >> mhf_pkg::HEAT_FRAC;
    if (lvl > mhf_pkg::LEVEL_MAX) lvl = mhf_pkg::LEVEL_MAX;
    return lvl[mhf_pkg::LEVEL_W-1:0];
  endfunction

  function automatic stim_row_t pixel_row(input logic [9:0] x, input logic [9:0] y);
    return '{kind: ROW_PIXEL, a: x, b: y, known: 1'b0, level: '0};
  endfunction

  function automatic stim_row_t pixel_row_known(input logic [9:0] x, input logic [9:0] y,
                                                input logic [mhf_pkg::LEVEL_W-1:0] lvl);
    return '{kind: ROW_PIXEL, a: x, b: y, known: 1'b1, level: lvl};
  endfunction

  function automatic stim_row_t reg_row(input logic [mhf_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [mhf_pkg::CFG_DATA_W-1:0] data);
    return '{kind: ROW_REG, a: 10'(idx), b: data, known: 1'b0, level: '0};
  endfunction

  function automatic logic [mhf_pkg::COORD_W-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return mhf_pkg::COORD_W'(COORD_MAX);
    return mhf_pkg::COORD_W'(v);
  endfunction

  // This offers one pixel after a random gap, or with no gap when the sender is calm. The payload
  // is held until the transfer completes, and the expected level is recorded at that same edge.
  task automatic send_pixel(input logic [mhf_pkg::COORD_W-1:0] px,
                            input logic [mhf_pkg::COORD_W-1:0] py,
                            input logic known,
                            input logic [mhf_pkg::LEVEL_W-1:0] known_level);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pixel_x_i  = px;
    pixel_y_i  = py;
    do @(posedge clk_i); while (in_stall_o);
    level_expected_q.push_back(known ? known_level : shade_level(px, py));
  endtask

  // This withdraws the input and waits until every owed level has come out. The lanes read
  // the registers live, so a write before this point would corrupt pixels still in flight.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (level_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // This is one write transfer on the configuration channel. The local copy is updated with
  // the value masked to the register's width, and unknown indexes are ignored.
  task automatic write_reg(input logic [mhf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mhf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mhf_pkg::CFG_B0_CX: blob_model[0].cx = data[mhf_pkg::COORD_W-1:0];
      mhf_pkg::CFG_B0_CY: blob_model[0].cy = data[mhf_pkg::COORD_W-1:0];
      mhf_pkg::CFG_B0_R:  blob_model[0].r  = data[mhf_pkg::RAD_W-1:0];
      mhf_pkg::CFG_B1_CX: blob_model[1].cx = data[mhf_pkg::COORD_W-1:0];
      mhf_pkg::CFG_B1_CY: blob_model[1].cy = data[mhf_pkg::COORD_W-1:0];
      mhf_pkg::CFG_B1_R:  blob_model[1].r  = data[mhf_pkg::RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // This returns a radius value to write. Most values are in range, but some use the whole
  // 10-bit data field, so the masking is exercised and a zero radius can appear.
  function automatic logic [mhf_pkg::CFG_DATA_W-1:0] draw_radius();
    case ($urandom_range(0, 3))
      0:       return mhf_pkg::CFG_DATA_W'($urandom_range(0, (1 << mhf_pkg::CFG_DATA_W) - 1));
      1:       return mhf_pkg::CFG_DATA_W'($urandom_range(1, 16));
      default: return mhf_pkg::CFG_DATA_W'($urandom_range(1, (1 << mhf_pkg::RAD_W) - 1));
    endcase
  endfunction

  // The receiver holds out_stall_i for a drawn number of cycles after each transfer. On
  // request it holds off for a long stretch instead, which fills the pipeline and pushes
  // in_stall_o high. It also checks each output transfer against the oldest expected level.
  initial begin
    int hold_left;
    int long_hold_served;
    logic [mhf_pkg::LEVEL_W-1:0] want;
    hold_left        = 0;
    long_hold_served = 0;
    out_stall_i      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_served < long_hold_requested) begin
        long_hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = 1'b0;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (level_expected_q.size() == 0) begin
          $error("level: no result expected, actual %0d", level_o);
          mismatch_count++;
        end else begin
          want = level_expected_q.pop_front();
          if (level_o !== want) begin
            $error("level: expected %0d, actual %0d", want, level_o);
            mismatch_count++;
          end
        end
        hold_left = receiver_calm ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // Main stimulus. It applies reset, walks the directed table and then runs a series of
  // random geometry phases.
  initial begin
    logic [mhf_pkg::CFG_DATA_W-1:0] b0cx, b0cy, b0r, b1cx, b1cy, b1r;
    logic [mhf_pkg::COORD_W-1:0]    px, py;
    int                             pick, spread;
    stim_row_t                      row;

    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    pixel_x_i           = '0;
    pixel_y_i           = '0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = '0;
    cfg_data_i          = '0;
    mismatch_count      = 0;
    sender_calm         = 1'b0;
    receiver_calm       = 1'b0;
    long_hold_requested = 0;
    blob_model[0] = '{cx: mhf_pkg::RST_B0_CX, cy: mhf_pkg::RST_B0_CY, r: mhf_pkg::RST_B0_R};
    blob_model[1] = '{cx: mhf_pkg::RST_B1_CX, cy: mhf_pkg::RST_B1_CY, r: mhf_pkg::RST_B1_R};

    // These rows use the default geometry: blob 0 at (300,200) with radius 100, and blob 1
    // at (400,230) with radius 75. Corners are far from both blobs. A blob centre gives a
    // full contribution, worth 170. A pixel on the rim of a blob gives nothing.
    directed_rows.push_back(pixel_row_known(10'd0, 10'd0, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd1023, 10'd1023, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd300, 10'd200, 8'd170));
    directed_rows.push_back(pixel_row_known(10'd400, 10'd230, 8'd170));
    directed_rows.push_back(pixel_row_known(10'd200, 10'd200, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd300, 10'd300, 8'd0));
    directed_rows.push_back(pixel_row(10'd350, 10'd215));
    directed_rows.push_back(pixel_row(10'd400, 10'd200));
    // In the next rows both blobs sit in the corner with the largest radius, and the second
    // radius is written as 1023 so that it must be masked to 511. At the shared centre the
    // two contributions overlap and the level saturates.
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B0_CX, 10'd0));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B0_CY, 10'd0));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B0_R, 10'd511));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_CX, 10'd0));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_CY, 10'd0));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_R, 10'd1023));
    directed_rows.push_back(pixel_row_known(10'd0, 10'd0, 8'd255));
    directed_rows.push_back(pixel_row_known(10'd1023, 10'd1023, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd0, 10'd511, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd511, 10'd0, 8'd0));
    directed_rows.push_back(pixel_row(10'd100, 10'd100));
    // Next, blob 1 moves to the far corner with a zero radius. Only blob 0 then contributes.
    // Writes to the unused indexes must change nothing.
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_CX, 10'd1023));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_CY, 10'd1023));
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_R, 10'd0));
    directed_rows.push_back(pixel_row_known(10'd0, 10'd0, 8'd170));
    directed_rows.push_back(pixel_row_known(10'd1023, 10'd1023, 8'd0));
    directed_rows.push_back(pixel_row_known(10'd1023, 10'd0, 8'd0));
    directed_rows.push_back(reg_row(CFG_SPARE_LO, 10'd1023));
    directed_rows.push_back(reg_row(CFG_SPARE_HI, 10'd1023));
    directed_rows.push_back(pixel_row_known(10'd0, 10'd0, 8'd170));
    // The smallest radius: its centre gets the full contribution, and its neighbour is on the rim.
    directed_rows.push_back(reg_row(mhf_pkg::CFG_B1_R, 10'd1));
    directed_rows.push_back(pixel_row_known(10'd1023, 10'd1023, 8'd170));
    directed_rows.push_back(pixel_row_known(10'd1022, 10'd1023, 8'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        wait_drained();
        write_reg(row.a[mhf_pkg::CFG_IDX_W-1:0], row.b);
      end else begin
        send_pixel(row.a, row.b, row.known, row.level);
      end
    end

    // Random phases. The first three use fixed extreme geometry. The rest draw centres and
    // radii at random, and often place blob 1 close to blob 0 so that the two overlap.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          b0cx = 10'd0;    b0cy = 10'd0;    b0r = 10'd1;
          b1cx = 10'd0;    b1cy = 10'd0;    b1r = 10'd1;
        end
        1: begin
          b0cx = 10'd1023; b0cy = 10'd1023; b0r = 10'd511;
          b1cx = 10'd1023; b1cy = 10'd1023; b1r = 10'd511;
        end
        2: begin
          b0cx = 10'd0;    b0cy = 10'd1023; b0r = 10'd511;
          b1cx = 10'd1023; b1cy = 10'd0;    b1r = 10'd511;
        end
        default: begin
          b0cx = mhf_pkg::CFG_DATA_W'($urandom_range(0, COORD_MAX));
          b0cy = mhf_pkg::CFG_DATA_W'($urandom_range(0, COORD_MAX));
          b0r  = draw_radius();
          b1r  = draw_radius();
          if ($urandom_range(0, 1) == 0) begin
            b1cx = clamp_coord(int'(b0cx) + int'($urandom_range(0, 128)) - 64);
            b1cy = clamp_coord(int'(b0cy) + int'($urandom_range(0, 128)) - 64);
          end else begin
            b1cx = mhf_pkg::CFG_DATA_W'($urandom_range(0, COORD_MAX));
            b1cy = mhf_pkg::CFG_DATA_W'($urandom_range(0, COORD_MAX));
          end
        end
      endcase
      if (ph % 2 == 1) write_reg(CFG_SPARE_LO, mhf_pkg::CFG_DATA_W'($urandom));
      write_reg(mhf_pkg::CFG_B0_CX, b0cx);
      write_reg(mhf_pkg::CFG_B0_CY, b0cy);
      write_reg(mhf_pkg::CFG_B0_R, b0r);
      write_reg(mhf_pkg::CFG_B1_CX, b1cx);
      write_reg(mhf_pkg::CFG_B1_CY, b1cy);
      write_reg(mhf_pkg::CFG_B1_R, b1r);
      if (ph % 2 == 1) write_reg(CFG_SPARE_HI, mhf_pkg::CFG_DATA_W'($urandom));

      // Some phases run without gaps on one side or on both, so that back-to-back transfers
      // are covered as well.
      sender_calm   = (ph % 3 == 1);
      receiver_calm = (ph % 4 == 2);
      if (ph == 4) long_hold_requested++;

      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 4);
        if (pick == 0) begin
          px = mhf_pkg::COORD_W'($urandom_range(0, COORD_MAX));
          py = mhf_pkg::COORD_W'($urandom_range(0, COORD_MAX));
        end else begin
          // Most pixels fall in a box just wider than a blob, so interiors and rims are
          // both hit often.
          pick   = (pick <= 2) ? 0 : 1;
          spread = int'(blob_model[pick].r) + 2;
          px = clamp_coord(int'(blob_model[pick].cx) + int'($urandom_range(0, 2 * spread))
                           - spread);
          py = clamp_coord(int'(blob_model[pick].cy) + int'($urandom_range(0, 2 * spread))
                           - spread);
        end
        send_pixel(px, py, 1'b0, '0);
      end
    end

    // Let the last levels drain, then watch for a while for any stray output transfer.
    receiver_calm = 1'b1;
    wait_drained();
    repeat (mhf_pkg::PIPE_LAT + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/core/mhf_pkg.sv
rtl/core/mhf_sqrt.sv
rtl/core/mhf_div.sv
rtl/core/mhf_blob.sv
rtl/core/metaball_heat_field_shader_core.sv
tb/tb_top.sv
